// ===== src/sph_pkg.sv =====
// ----------------------------------------------------------------------------
// sph_pkg: shared types and constants for the density accumulator
// Holds the command type that crosses the front-to-back queue and the
// register index codes.
// ----------------------------------------------------------------------------
package sph_pkg;

  localparam int ACC_BITS_DEF = 48;
  localparam int OUT_BITS     = 48;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVR  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_POLY6 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEAR  = 2'd3;

  // one classified item: per-axis magnitude of the difference plus flags
  typedef struct packed {
    logic [32:0] mag_x;
    logic [32:0] mag_y;
    logic [32:0] mag_z;
    logic        has_nb;
    logic        last;
    logic        mode;
  } sph_cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_MUL, BK_SQ, BK_SUM, BK_SQRT, BK_POW1, BK_POW2,
    BK_SCALE, BK_ACC, BK_SELF, BK_OUT
  } bk_state_t;

endpackage

// ===== src/sph_front.sv =====
// ----------------------------------------------------------------------------
// sph_front: input stage
// Accepts items, forms exact position differences and their magnitudes.
// ----------------------------------------------------------------------------
module sph_front
  import sph_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic signed [31:0] in_neighbor_x,
  input  logic signed [31:0] in_neighbor_y,
  input  logic signed [31:0] in_neighbor_z,
  input  logic               in_has_neighbor,
  input  logic               in_is_last,
  input  logic               mode,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output sph_cmd_t           cmd
);

  sph_cmd_t cmd_r;
  logic     valid_r;

  function automatic logic [32:0] absdiff(input logic signed [31:0] n,
                                          input logic signed [31:0] c);
    logic signed [32:0] d;
    d = 33'(n) - 33'(c);
    absdiff = d[32] ? 33'(-d) : d;
  endfunction

  assign in_ready  = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r.mag_x  <= absdiff(in_neighbor_x, in_center_x);
      cmd_r.mag_y  <= absdiff(in_neighbor_y, in_center_y);
      cmd_r.mag_z  <= absdiff(in_neighbor_z, in_center_z);
      cmd_r.has_nb <= in_has_neighbor;
      cmd_r.last   <= in_is_last;
      cmd_r.mode   <= mode;
    end
  end

endmodule

// ===== src/sph_queue.sv =====
// ----------------------------------------------------------------------------
// sph_queue: two-entry command queue
// Decouples the input stage from the kernel engine.
// ----------------------------------------------------------------------------
module sph_queue
  import sph_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  sph_cmd_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output sph_cmd_t rd_data
);

  sph_cmd_t  mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic      wr_en, rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

`ifndef NO_ASSERTIONS
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr_ready) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !wr_en) |=> !rd_valid) else $error("phantom read");
`endif

endmodule

// ===== src/sph_back.sv =====
// ----------------------------------------------------------------------------
// sph_back: kernel engine
// Sequences distance, square root, powers, scaling and saturating sums.
// ----------------------------------------------------------------------------
module sph_back
  import sph_pkg::*;
#(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  sph_cmd_t    cmd,
  input  logic [31:0] inv_radius,
  input  logic [31:0] poly6_scale,
  input  logic [31:0] near_scale,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [OUT_BITS-1:0] out_density,
  output logic [OUT_BITS-1:0] out_near_rho
);

  localparam logic [ACC_BITS-1:0] AMAX = {ACC_BITS{1'b1}};

  bk_state_t state_r, state_nxt;
  sph_cmd_t  c_r;
  logic [1:0]  ax_r;
  logic [63:0] t_r;
  logic [33:0] s_r;
  logic [63:0] rem_r;
  logic [31:0] q_r;
  logic [5:0]  it_r;
  logic [47:0] pa_r, pb_r;
  logic [63:0] ta_r, tb_r;
  logic [ACC_BITS-1:0] dsum_r, nsum_r;
  logic [OUT_BITS-1:0] od_r, on_r;
  logic        ov_r;
  logic [63:0] x_r;

  logic [32:0] mag;
  logic [63:0] prod;
  logic [63:0] sq;
  logic [16:0] a16, b16;

  function automatic logic [ACC_BITS-1:0] sadd(input logic [ACC_BITS-1:0] a,
                                               input logic [63:0] b);
    logic [64:0] s;
    s = 65'(a) + 65'(b);
    sadd = (s > 65'(AMAX)) ? AMAX : s[ACC_BITS-1:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] clampo(input logic [ACC_BITS-1:0] v);
    clampo = (64'(v) > 64'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : OUT_BITS'(v);
  endfunction

  always_comb begin
    case (ax_r)
      2'd0:    mag = c_r.mag_x;
      2'd1:    mag = c_r.mag_y;
      default: mag = c_r.mag_z;
    endcase
    prod  = 64'(mag[31:0]) * 64'(inv_radius);
    sq    = 64'(t_r[31:0]) * 64'(t_r[31:0]);
    a16   = 17'((34'h1_0000_0000 - s_r) >> 16);
    b16   = 17'((33'h1_0000_0000 - 33'(q_r)) >> 16);
  end

  // isqrt step on x = s << 32, one result bit per cycle
  logic [65:0] rem2;
  logic [33:0] tst;
  assign rem2 = {rem_r, x_r[63:62]};
  assign tst  = {q_r, 2'b01};

  assign cmd_ready        = state_r == BK_IDLE && !ov_r;
  assign out_valid        = ov_r;
  assign out_density      = od_r;
  assign out_near_rho     = on_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (cmd_valid && cmd_ready)
                  state_nxt = cmd.has_nb ? BK_MUL : (cmd.last ? BK_SELF : BK_IDLE);
      BK_MUL:   state_nxt = BK_SQ;
      BK_SQ:    state_nxt = (ax_r == 2'd2) ? BK_SUM : BK_MUL;
      BK_SUM:   state_nxt = BK_SQRT;
      BK_SQRT:  state_nxt = (it_r == 6'd31) ? BK_POW1 : BK_SQRT;
      BK_POW1:  state_nxt = BK_POW2;
      BK_POW2:  state_nxt = BK_SCALE;
      BK_SCALE: state_nxt = BK_ACC;
      BK_ACC:   state_nxt = c_r.last ? BK_SELF : BK_IDLE;
      BK_SELF:  state_nxt = BK_OUT;
      BK_OUT:   state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  logic skip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
      dsum_r  <= '0;
      nsum_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        BK_ACC: if (!skip_r) begin
          dsum_r <= sadd(dsum_r, ta_r);
          nsum_r <= sadd(nsum_r, tb_r);
        end
        BK_SELF: if (!c_r.mode) begin
          dsum_r <= sadd(dsum_r, 64'(poly6_scale));
          nsum_r <= sadd(nsum_r, 64'(near_scale));
        end
        BK_OUT: begin
          ov_r   <= 1'b1;
          dsum_r <= '0;
          nsum_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath; skipped neighbors run through and add nothing
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: if (cmd_valid && cmd_ready) begin
        c_r    <= cmd;
        ax_r   <= 2'd0;
        s_r    <= '0;
        skip_r <= 1'b0;
      end
      BK_MUL: begin
        if (mag[32] || (prod[63:32] != 32'd0 && inv_radius != 32'd0)) skip_r <= 1'b1;
        t_r <= prod;
      end
      BK_SQ: begin
        s_r <= s_r + 34'(sq[63:32]);
        if (ax_r != 2'd2) begin
          ax_r <= ax_r + 2'd1;
        end
      end
      BK_SUM: begin
        if (s_r[33:32] != 2'b00) skip_r <= 1'b1;
        x_r   <= {s_r[31:0], 32'd0};
        rem_r <= '0;
        q_r   <= '0;
        it_r  <= '0;
      end
      BK_SQRT: begin
        if (rem2 >= 66'(tst)) begin
          rem_r <= 64'(rem2 - 66'(tst));
          q_r   <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= rem2[63:0];
          q_r   <= {q_r[30:0], 1'b0};
        end
        x_r  <= {x_r[61:0], 2'b00};
        it_r <= it_r + 6'd1;
      end
      BK_POW1: begin
        pa_r <= 48'(34'(a16) * 34'(a16));
        pb_r <= 48'(34'(b16) * 34'(b16));
      end
      BK_POW2: begin
        // cubes reach 2^48 at zero distance
        ta_r <= (64'(pa_r[32:0]) * 64'(a16)) >> 16;
        tb_r <= c_r.mode ? ((64'(pb_r[32:0]) * 64'(b16)) >> 32)
                         : ((64'(pb_r[32:0]) * 64'(b16)) >> 16);
        pa_r <= pb_r >> 16;
      end
      BK_SCALE: begin
        if (c_r.mode) begin
          ta_r <= 64'(pa_r);
        end else begin
          ta_r <= (64'(poly6_scale) * 64'(ta_r[32:0])) >> 32;
          tb_r <= (64'(near_scale) * 64'(tb_r[32:0])) >> 32;
        end
      end
      BK_SELF: ;
      BK_OUT: begin
        od_r <= clampo(dsum_r);
        on_r <= clampo(nsum_r);
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BK_IDLE |-> !cmd_ready) else $error("ready while busy");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_OUT |=> out_valid) else $error("result lost");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_OUT |=> dsum_r == '0 && nsum_r == '0) else $error("sum not cleared");
`endif

endmodule

// ===== src/sph_density_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// sph_density_accumulator_unit: SPH density and near-density accumulator
// Sums kernel terms (poly6 and near in mode 0, unscaled powers in mode 1) over
// a neighbor run and returns both sums on the run's last item.
// ----------------------------------------------------------------------------
// channel | ports                          | transfer
// in      | in_valid/in_ready + fields     | one neighbor item
// out     | out_valid/out_ready + sums     | one result per run
// cfg     | cfg_we, cfg_index, cfg_data    | register write, no wait
//
// a neighbor item holds the kernel engine from its acceptance through the three
// axis products and squares, one range check, the bit-serial square root and
// the powers, scaling and sum steps.
// an empty item that is not last is taken and adds nothing.
// the last item adds the self-term and result-register states,
// then the engine waits until the result is taken.
// reset is synchronous active low and restores the register defaults.
// while a result waits, the input stage and the two-entry queue still take
// up to three items before in_ready drops.
// ----------------------------------------------------------------------------
module sph_density_accumulator_unit
  import sph_pkg::*;
#(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [31:0]      in_center_x,
  input  logic signed [31:0]      in_center_y,
  input  logic signed [31:0]      in_center_z,
  input  logic signed [31:0]      in_neighbor_x,
  input  logic signed [31:0]      in_neighbor_y,
  input  logic signed [31:0]      in_neighbor_z,
  input  logic                    in_has_neighbor,
  input  logic                    in_is_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_BITS-1:0]     out_density,
  output logic [OUT_BITS-1:0]     out_near_rho,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_data
);

  logic        mode_r;
  logic [31:0] invr_r, p6_r, nr_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      invr_r <= 32'd65536;
      p6_r   <= 32'd65536;
      nr_r   <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode_r <= cfg_data[0];
        REG_INVR:  invr_r <= cfg_data;
        REG_POLY6: p6_r   <= cfg_data;
        REG_NEAR:  nr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic     f_valid, f_ready, b_valid, b_ready;
  sph_cmd_t f_cmd, b_cmd;

  sph_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_center_x, .in_center_y, .in_center_z,
    .in_neighbor_x, .in_neighbor_y, .in_neighbor_z,
    .in_has_neighbor, .in_is_last,
    .mode(mode_r), .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  sph_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
  );

  sph_back #(.ACC_BITS(ACC_BITS)) u_back (
    .clk, .rst_n, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
    .inv_radius(invr_r), .poly6_scale(p6_r), .near_scale(nr_r),
    .out_valid, .out_ready, .out_density, .out_near_rho
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sph_density_accumulator_unit
// Streams neighbor runs through the input channel and predicts the density
// and near-density sums in 64-bit arithmetic, then checks every result
// transfer in order. Covers both kernel modes, radius and scale extremes,
// empty runs, a mode switch in the middle of a run, output back-pressure and
// about a thousand random items with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import sph_pkg::*;

  localparam longint unsigned ONE_Q32  = 64'h1_0000_0000;
  localparam longint unsigned SUM_MAX  = 64'hFFFF_FFFF_FFFF;
  localparam int              SETTLE   = 60;

  typedef struct packed {
    logic signed [31:0] cx, cy, cz, nx, ny, nz;
    logic               has_nb;
    logic               last;
  } nb_item_t;

  typedef struct packed {
    logic [47:0] density;
    logic [47:0] near_rho;
  } sums_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic signed [31:0] in_neighbor_x = '0, in_neighbor_y = '0, in_neighbor_z = '0;
  logic in_has_neighbor = 1'b0;
  logic in_is_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_BITS-1:0] out_density, out_near_rho;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sph_density_accumulator_unit uut (.*);

  always #10 clk = ~clk;

  // predictor copy of the registers and running sums
  bit              mode_q;
  longint unsigned inv_r, p6_scale, nr_scale;
  longint unsigned dens_acc, near_acc;

  sums_t expected_sums[$];
  int    error_count = 0;
  int    items_sent = 0;
  int    results_seen = 0;
  bit    calm = 1'b0;       // no idling while set
  bit    hold_req = 1'b0;   // asks the receiver for a long stall
  int    hold_left = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned bitv = 64'h1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned acc, longint unsigned term);
    if (term > SUM_MAX - acc) return SUM_MAX;
    return acc + term;
  endfunction

  function automatic longint unsigned axis_ratio(logic signed [31:0] c,
                                                 logic signed [31:0] n);
    longint d;
    longint unsigned mag;
    d = longint'(n) - longint'(c);
    mag = (d < 0) ? longint'(-d) : d;
    return mag * inv_r;
  endfunction

  // adds one neighbor's kernel terms, nothing at or beyond the radius
  function automatic void kernel_terms(nb_item_t it);
    longint unsigned t[3];
    longint unsigned s, q, a16, b16;
    t[0] = axis_ratio(it.cx, it.nx);
    t[1] = axis_ratio(it.cy, it.ny);
    t[2] = axis_ratio(it.cz, it.nz);
    s = 0;
    for (int i = 0; i < 3; i++) begin
      if (t[i] >= ONE_Q32) return;
      s += (t[i] * t[i]) >> 32;
    end
    if (s >= ONE_Q32) return;
    q = root64(s << 32);
    a16 = (ONE_Q32 - s) >> 16;
    b16 = (ONE_Q32 - q) >> 16;
    if (!mode_q) begin
      dens_acc = sat_sum(dens_acc, (p6_scale * ((a16 * a16 * a16) >> 16)) >> 32);
      near_acc = sat_sum(near_acc, (nr_scale * ((b16 * b16 * b16) >> 16)) >> 32);
    end else begin
      dens_acc = sat_sum(dens_acc, (b16 * b16) >> 16);
      near_acc = sat_sum(near_acc, (b16 * b16 * b16) >> 32);
    end
  endfunction

  function automatic void predict_item(nb_item_t it);
    sums_t r;
    if (it.has_nb) kernel_terms(it);
    if (!it.last) return;
    if (!mode_q) begin
      dens_acc = sat_sum(dens_acc, p6_scale);
      near_acc = sat_sum(near_acc, nr_scale);
    end
    r.density = dens_acc[47:0];
    r.near_rho = near_acc[47:0];
    expected_sums.push_back(r);
    dens_acc = 0;
    near_acc = 0;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_item(nb_item_t it);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_center_x <= it.cx;  in_center_y <= it.cy;  in_center_z <= it.cz;
    in_neighbor_x <= it.nx; in_neighbor_y <= it.ny; in_neighbor_z <= it.nz;
    in_has_neighbor <= it.has_nb;
    in_is_last <= it.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    items_sent++;
  endtask

  // lets the block drain, including items that give no result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:  mode_q = data[0];
      REG_INVR:  inv_r = data;
      REG_POLY6: p6_scale = data;
      REG_NEAR:  nr_scale = data;
      default: ;
    endcase
  endtask

  task automatic set_config(bit m, logic [31:0] inv, logic [31:0] p6, logic [31:0] nr);
    // upper bits of the mode word are junk on purpose
    write_reg(REG_MODE, {$urandom} & 32'hFFFF_FFFE | 32'(m));
    write_reg(REG_INVR, inv);
    write_reg(REG_POLY6, p6);
    write_reg(REG_NEAR, nr);
  endtask

  function automatic nb_item_t make_item(logic signed [31:0] cx, logic signed [31:0] cy,
                                         logic signed [31:0] cz, logic signed [31:0] nx,
                                         logic signed [31:0] ny, logic signed [31:0] nz,
                                         bit has_nb, bit last);
    nb_item_t it;
    it = '{cx, cy, cz, nx, ny, nz, has_nb, last};
    return it;
  endfunction

  // offset that keeps one axis inside the smoothing radius most of the time
  function automatic logic signed [31:0] near_offset();
    longint unsigned lim;
    logic signed [31:0] v;
    lim = (inv_r == 0) ? 64'h7FFF_FFFF : ((ONE_Q32 - 1) / inv_r) / 2;
    if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
    v = $urandom_range(0, 32'(lim));
    return $urandom_range(1) ? -v : v;
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    sums_t e;
    if (out_valid && out_ready) begin
      results_seen++;
      if (expected_sums.size() == 0) begin
        $error("result transfer with nothing expected: density %0d near %0d",
               out_density, out_near_rho);
        error_count++;
      end else begin
        e = expected_sums.pop_front();
        if (out_density !== e.density) begin
          $error("density: expected %0d, got %0d", e.density, out_density);
          error_count++;
        end
        if (out_near_rho !== e.near_rho) begin
          $error("near_rho: expected %0d, got %0d", e.near_rho, out_near_rho);
          error_count++;
        end
      end
    end
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // ---------------------------------------------------------------- tests
  // field extremes, zero distance, far neighbors, zero inverse radius
  task automatic test_extremes();
    logic signed [31:0] mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7FFF_FFFF;
    send_item(make_item(0, 0, 0, 0, 0, 0, 1, 1));            // self distance
    send_item(make_item(mn, mn, mn, mx, mx, mx, 1, 1));      // far away
    send_item(make_item(mx, mx, mx, mn, mn, mn, 1, 0));
    send_item(make_item(mx, mx, mx, mx, mx, mx, 1, 1));
    send_item(make_item(0, 0, 0, 32'sd65535, 0, 0, 1, 0));   // just inside
    send_item(make_item(0, 0, 0, 32'sd65536, 0, 0, 1, 0));   // at the radius
    send_item(make_item(0, 0, 0, 0, -32'sd40000, 32'sd30000, 1, 1));
    send_item(make_item(mn, 0, mx, mn, 0, mx, 1, 1));
    wait_idle();
    set_config(1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(make_item(0, 0, 0, 32'sd1000, 32'sd2000, -32'sd3000, 1, 0));
    send_item(make_item(0, 0, 0, 0, 0, 0, 1, 0));
    send_item(make_item(0, 0, 0, 32'sd65536, 0, 0, 1, 1));
    wait_idle();
    // zero inverse radius: all neighbors at distance zero
    set_config(0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(make_item(mn, mn, mn, mx, mx, mx, 1, 0));
    send_item(make_item(mx, 0, mn, 0, mx, 0, 1, 1));
    wait_idle();
    set_config(0, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_item(make_item(5, 5, 5, 5, 5, 5, 1, 0));
    send_item(make_item(5, 5, 5, 6, 5, 5, 1, 1));
    wait_idle();
    set_config(0, 32'h1, 32'hFFFF_FFFF, 32'h1234_5678);
    send_item(make_item(mn, mn, mn, mx, mx, mx, 1, 1));
    send_item(make_item(0, 0, 0, mx, 0, 0, 1, 1));
    wait_idle();
  endtask

  // runs with no neighbor, in both modes
  task automatic test_empty_runs();
    set_config(0, 32'h0001_0000, 32'h0003_2000, 32'h0000_8001);
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 1));
    send_item(make_item(1, 2, 3, 4, 5, 6, 0, 0));
    send_item(make_item(1, 2, 3, 4, 5, 6, 0, 1));
    wait_idle();
    set_config(1, 32'h0002_0000, 32'h0003_2000, 32'h0000_8001);
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 1));
    wait_idle();
  endtask

  // sums carry over a mode change; self terms follow the mode at the last item
  task automatic test_mode_switch_mid_run();
    set_config(0, 32'h0001_0000, 32'h0010_0000, 32'h0020_0000);
    send_item(make_item(0, 0, 0, 32'sd20000, 0, 0, 1, 0));
    wait_idle();
    write_reg(REG_MODE, 32'h1);
    send_item(make_item(0, 0, 0, 0, 32'sd10000, 0, 1, 1));
    send_item(make_item(0, 0, 0, 0, 0, 32'sd5000, 1, 0));
    wait_idle();
    write_reg(REG_MODE, 32'h0);
    send_item(make_item(0, 0, 0, 0, 0, 32'sd5000, 1, 1));
    wait_idle();
  endtask

  // receiver stalls while short runs keep arriving, so the input backs up
  task automatic test_backpressure();
    nb_item_t it;
    hold_req <= 1'b1;
    for (int i = 0; i < 12; i++) begin
      it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 1);
      if (i % 3 == 0) begin
        it.has_nb = 1'b1;
        it.nx = it.cx + near_offset();
      end
      send_item(it);
    end
    wait_idle();
  endtask

  task automatic random_runs(int n_items);
    nb_item_t it;
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 8);
      it.cx = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(0, 32'hFFFFF)) - 32'sh80000;
      it.cy = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(0, 32'hFFFFF)) - 32'sh80000;
      it.cz = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(0, 32'hFFFFF)) - 32'sh80000;
      for (int k = 0; k < len && left > 0; k++) begin
        if ($urandom_range(9) == 0) begin
          // noise: random neighbor, mostly out of range
          it.nx = $urandom; it.ny = $urandom; it.nz = $urandom;
        end else begin
          it.nx = it.cx + near_offset();
          it.ny = it.cy + near_offset();
          it.nz = it.cz + near_offset();
        end
        it.has_nb = ($urandom_range(9) != 0);
        it.last = (k == len - 1) || (left == 1);
        send_item(it);
        left--;
      end
    end
  endtask

  task automatic test_random();
    logic [31:0] invs[5];
    invs = '{32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0};
    for (int ph = 0; ph < 8; ph++) begin
      set_config(ph[0], (ph < 5) ? invs[ph] : $urandom,
                 (ph == 6) ? 32'hFFFF_FFFF : $urandom,
                 (ph == 7) ? 32'h0 : $urandom);
      calm = (ph == 3);
      random_runs(125);
      calm = 1'b0;
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    mode_q = 1'b0;
    inv_r = 65536;
    p6_scale = 65536;
    nr_scale = 65536;
    dens_acc = 0;
    near_acc = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_empty_runs();
    test_mode_switch_mid_run();
    test_backpressure();
    test_random();
    wait_idle();
    $display("covered %0d input items and %0d results over both modes,", items_sent,
             results_seen);
    $display("radius and scale extremes, empty runs, mode switch and a long output stall");
    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sph_density_accumulator_unit.f =====
src/sph_pkg.sv
src/sph_front.sv
src/sph_queue.sv
src/sph_back.sv
src/sph_density_accumulator_unit.sv
test/testbench.sv
